// ===== rtl/core/trc_pkg.sv =====
// ----------------------------------------------------------------------------
// trc_pkg
// Shared types, constants and the arctangent lookup for the tilt risk
// classifier.
// ----------------------------------------------------------------------------
package trc_pkg;

  // CORDIC datapath widths
  localparam int CW       = 35;   // x/y working registers, signed
  localparam int AW       = 34;   // angle accumulator, degrees * 2^ACC_FRAC
  localparam int ACC_FRAC = 24;
  localparam int ATAN_W   = 30;
  localparam int TAB_IW   = 5;    // index width of the atan lookup (24 entries)

  // Root unit
  localparam int MAG_W       = 32;
  localparam int SQ_W        = 64;
  localparam int ROOT_ITERS  = 32;
  localparam int ROOT_CNT_W  = 5;
  localparam logic [SQ_W-1:0] ROOT_FIRST_BIT = 64'h4000_0000_0000_0000;

  // Normalizer: shifts of 16, 8, 4, 2, 1
  localparam int NORM_STEPS = 5;
  localparam int NORM_CNT_W = 3;
  localparam int NORM_SH_W  = 5;
  localparam logic [NORM_SH_W-1:0] NORM_FIRST_SH = 5'd16;
  localparam logic [MAG_W-1:0]     NORM_TOP      = 32'h8000_0000;

  // +180 degrees in accumulator units
  localparam logic signed [AW-1:0] ACC_180 = 34'sd3019898880;

  // Result layout
  localparam int SEQ_W      = 16;
  localparam int ROLL_W     = 17;
  localparam int PITCH_W    = 16;
  localparam int DOUT_W     = 16;
  localparam int RISK_W     = 2;
  localparam int OUT_DATA_W = 72;
  localparam int OUT_PAD_W  = OUT_DATA_W - (SEQ_W + ROLL_W + PITCH_W + DOUT_W + RISK_W);

  // APB
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = 2;
  localparam logic [REG_IDX_W-1:0] REG_TILT_LIMIT = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_EMERGENCY  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_CAUTION    = 2'd2;

  localparam int TILT_W = 8;
  localparam int DTH_W  = 16;
  localparam logic [TILT_W-1:0] TILT_RESET      = 8'd35;
  localparam logic [DTH_W-1:0]  EMERGENCY_RESET = 16'd280;
  localparam logic [DTH_W-1:0]  CAUTION_RESET   = 16'd550;

  typedef enum logic [RISK_W-1:0] {
    RISK_NORMAL    = 2'd0,
    RISK_CAUTION   = 2'd1,
    RISK_EMERGENCY = 2'd2
  } risk_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROLL_SETUP,
    ST_ROLL_NORM,
    ST_ROLL_START,
    ST_ROLL_WAIT,
    ST_PITCH_SETUP,
    ST_PITCH_NORM,
    ST_ROOT_START,
    ST_ROOT_WAIT,
    ST_PITCH_START,
    ST_PITCH_WAIT,
    ST_DONE
  } trc_state_t;

  typedef enum logic [1:0] {
    CD_IDLE,
    CD_RUN,
    CD_DONE
  } cd_state_t;

  typedef enum logic [2:0] {
    RT_IDLE,
    RT_SQ_A,
    RT_SQ_B,
    RT_SUM,
    RT_ITER,
    RT_DONE
  } rt_state_t;

  typedef struct packed {
    logic [TILT_W-1:0] tilt_limit_deg;
    logic [DTH_W-1:0]  emergency_distance_mm;
    logic [DTH_W-1:0]  caution_distance_mm;
  } cfg_regs_t;

  typedef struct packed {
    logic                   start;
    logic signed [CW-1:0]   y;
    logic signed [CW-1:0]   x;
    logic signed [AW-1:0]   acc;
  } cordic_req_t;

  // atan(2^-i) in degrees * 2^24, rounded to nearest
  function automatic logic [ATAN_W-1:0] atan_entry(input logic [TAB_IW-1:0] idx);
    logic [ATAN_W-1:0] v;
    case (idx)
      5'd0:  v = 30'd754974720;
      5'd1:  v = 30'd445687602;
      5'd2:  v = 30'd235489088;
      5'd3:  v = 30'd119537938;
      5'd4:  v = 30'd60000934;
      5'd5:  v = 30'd30029717;
      5'd6:  v = 30'd15018523;
      5'd7:  v = 30'd7509720;
      5'd8:  v = 30'd3754917;
      5'd9:  v = 30'd1877466;
      5'd10: v = 30'd938734;
      5'd11: v = 30'd469367;
      5'd12: v = 30'd234684;
      5'd13: v = 30'd117342;
      5'd14: v = 30'd58671;
      5'd15: v = 30'd29335;
      5'd16: v = 30'd14668;
      5'd17: v = 30'd7334;
      5'd18: v = 30'd3667;
      5'd19: v = 30'd1833;
      5'd20: v = 30'd917;
      5'd21: v = 30'd458;
      5'd22: v = 30'd229;
      5'd23: v = 30'd115;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/core/trc_cfg.sv =====
// ----------------------------------------------------------------------------
// trc_cfg
// APB register file: tilt limit and the two distance thresholds.
// ----------------------------------------------------------------------------
module trc_cfg import trc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output cfg_regs_t             regs
);

  logic [REG_IDX_W-1:0] idx;
  logic                 wr_en;

  assign idx   = paddr[APB_ADDR_W-1:2];
  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.tilt_limit_deg        <= TILT_RESET;
      regs.emergency_distance_mm <= EMERGENCY_RESET;
      regs.caution_distance_mm   <= CAUTION_RESET;
    end else if (wr_en) begin
      unique case (idx)
        REG_TILT_LIMIT: regs.tilt_limit_deg        <= pwdata[TILT_W-1:0];
        REG_EMERGENCY:  regs.emergency_distance_mm <= pwdata[DTH_W-1:0];
        REG_CAUTION:    regs.caution_distance_mm   <= pwdata[DTH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_TILT_LIMIT: prdata = APB_DATA_W'(regs.tilt_limit_deg);
      REG_EMERGENCY:  prdata = APB_DATA_W'(regs.emergency_distance_mm);
      REG_CAUTION:    prdata = APB_DATA_W'(regs.caution_distance_mm);
      default:        prdata = '0;
    endcase
  end

endmodule

// ===== rtl/core/trc_isqrt.sv =====
// ----------------------------------------------------------------------------
// trc_isqrt
// floor(sqrt(a^2 + b^2)): one shared squarer, then one result bit per cycle.
// ----------------------------------------------------------------------------
module trc_isqrt import trc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [MAG_W-1:0] a,
  input  logic [MAG_W-1:0] b,
  output logic             done,
  output logic [MAG_W-1:0] root
);

  rt_state_t state, state_next;

  logic [MAG_W-1:0]      oa, ob, mul_op;
  logic [SQ_W-1:0]       prod, sq_a, sq_b, n, res, bitv, trial;
  logic [ROOT_CNT_W-1:0] cnt;
  logic                  take;

  assign prod  = {MAG_W'(0), mul_op} * {MAG_W'(0), mul_op};
  assign trial = res + bitv;
  assign take  = n >= trial;
  assign root  = res[MAG_W-1:0];

  always_comb begin
    state_next = state;
    unique case (state)
      RT_IDLE: if (start) state_next = RT_SQ_A;
      RT_SQ_A: state_next = RT_SQ_B;
      RT_SQ_B: state_next = RT_SUM;
      RT_SUM:  state_next = RT_ITER;
      RT_ITER: if (cnt == ROOT_CNT_W'(ROOT_ITERS - 1)) state_next = RT_DONE;
      RT_DONE: state_next = RT_IDLE;
      default: state_next = RT_IDLE;
    endcase
  end

  always_comb begin
    done   = (state == RT_DONE);
    mul_op = (state == RT_SQ_B) ? ob : oa;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= RT_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    case (state)
      RT_IDLE: begin
        if (start) begin
          oa   <= a;
          ob   <= b;
          res  <= '0;
          bitv <= ROOT_FIRST_BIT;
          cnt  <= '0;
        end
      end
      RT_SQ_A: sq_a <= prod;
      RT_SQ_B: sq_b <= prod;
      RT_SUM:  n    <= sq_a + sq_b;
      RT_ITER: begin
        if (take) begin
          n   <= n - trial;
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        bitv <= bitv >> 2;
        cnt  <= cnt + ROOT_CNT_W'(1);
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/core/trc_cordic.sv =====
// ----------------------------------------------------------------------------
// trc_cordic
// Vectoring CORDIC, one micro-rotation per cycle, shared by roll and pitch.
// Angle out is rounded to ANGLE_FRAC_BITS and clamped to +-180 degrees.
// ----------------------------------------------------------------------------
module trc_cordic import trc_pkg::*; #(
  parameter int ANGLE_FRAC_BITS = 8,
  parameter int CORDIC_STEPS    = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  cordic_req_t                       req,
  output logic                              done,
  output logic signed [ANGLE_FRAC_BITS+8:0] angle
);

  localparam int IW    = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam int ANG_W = ANGLE_FRAC_BITS + 9;
  localparam int RSH   = ACC_FRAC - ANGLE_FRAC_BITS;
  localparam logic [IW-1:0]        LAST = IW'(CORDIC_STEPS - 1);
  localparam logic signed [AW-1:0] HALF = AW'(longint'(1) << (RSH - 1));
  localparam logic signed [AW-1:0] LIM  = AW'(longint'(180) << ANGLE_FRAC_BITS);

  cd_state_t state, state_next;

  logic [IW-1:0]        step;
  logic signed [CW-1:0] x, y, xs, ys;
  logic signed [AW-1:0] acc, tab, acc_rnd, acc_q;

  assign xs      = x >>> step;
  assign ys      = y >>> step;
  assign tab     = AW'(atan_entry(TAB_IW'(step)));
  assign acc_rnd = acc + HALF;
  assign acc_q   = acc_rnd >>> RSH;

  always_comb begin
    if (acc_q > LIM)       angle = LIM[ANG_W-1:0];
    else if (acc_q < -LIM) angle = ANG_W'(-LIM);
    else                   angle = acc_q[ANG_W-1:0];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      CD_IDLE: if (req.start) state_next = CD_RUN;
      CD_RUN:  if (step == LAST) state_next = CD_DONE;
      CD_DONE: state_next = CD_IDLE;
      default: state_next = CD_IDLE;
    endcase
  end

  always_comb begin
    done = (state == CD_DONE);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= CD_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (state == CD_IDLE && req.start) begin
      y    <= req.y;
      x    <= req.x;
      acc  <= req.acc;
      step <= '0;
    end else if (state == CD_RUN) begin
      if (!y[CW-1]) begin
        x   <= x + ys;
        y   <= y - xs;
        acc <= acc + tab;
      end else begin
        x   <= x - ys;
        y   <= y + xs;
        acc <= acc - tab;
      end
      step <= step + IW'(1);
    end
  end

endmodule

// ===== rtl/core/tilt_risk_classifier.sv =====
// ----------------------------------------------------------------------------
// tilt_risk_classifier
// Roll/pitch from a 3-axis accelerometer frame plus obstacle distance
// grading into normal / caution / emergency, with a frame sequence stamp.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake                 carries
//  s_axis    in   s_axis_tvalid/tready      one sensor frame
//  m_axis    out  m_axis_tvalid/tready      one classified result
//  apb       in   psel/penable, pready=1    tilt limit, distance thresholds
//
// Work: a general frame runs the 32-step square root and two CORDIC passes
//   on the one shared rotator. A roll with a zero y or z input skips its
//   pass; a pitch with zero x, or zero y and z, skips the root and its pass.
// Reset: rst is synchronous; it clears the sequencer, the output valid and
//   the frame counter, and loads the register defaults.
// Stalls: s_axis_tready is high only in idle. A finished result sits in the
//   output register, so the next frame is taken while it waits; a second
//   result holds in the done state until m_axis_tready frees that register.
//
module tilt_risk_classifier import trc_pkg::*; #(
  parameter int ACCEL_BITS      = 16,
  parameter int DIST_BITS       = 16,
  parameter int ANGLE_FRAC_BITS = 8,
  parameter int CORDIC_STEPS    = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  // frame in
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // accel_x, accel_y, accel_z, obstacle_distance (lowest bit up), zero pad
  input  logic [((3*ACCEL_BITS+DIST_BITS+7)/8)*8-1:0] s_axis_tdata,
  // ranger_valid
  input  logic [0:0]             s_axis_tuser,
  // result out
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // sequence_res, roll_angle, pitch_angle, distance_out, risk_level
  // (lowest bit up), zero pad
  output logic [OUT_DATA_W-1:0]  m_axis_tdata,
  // APB config
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [APB_ADDR_W-1:0]  paddr,
  input  logic [APB_DATA_W-1:0]  pwdata,
  output logic [APB_DATA_W-1:0]  prdata,
  output logic                   pready
);

  localparam int ANG_W = ANGLE_FRAC_BITS + 9;
  localparam int A     = ACCEL_BITS;
  localparam int DXW   = DIST_BITS + DTH_W;
  localparam logic signed [ANG_W-1:0] ANG_90  = ANG_W'(90 << ANGLE_FRAC_BITS);
  localparam logic signed [ANG_W-1:0] ANG_180 = ANG_W'(180 << ANGLE_FRAC_BITS);

  function automatic logic [MAG_W-1:0] mag_of(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] av;
    av = v[CW-1] ? -v : v;
    return av[MAG_W-1:0];
  endfunction

  function automatic logic [MAG_W-1:0] max_of(input logic [MAG_W-1:0] p,
                                              input logic [MAG_W-1:0] q);
    return (p > q) ? p : q;
  endfunction

  trc_state_t state, state_next;
  cfg_regs_t  cfg;

  // captured frame
  logic signed [A-1:0]     in_x, in_y, in_z;
  logic [DIST_BITS-1:0]    in_dist;
  logic                    in_valid;

  // normalizer / working vector
  logic signed [CW-1:0]    wx, wy, wz;
  logic [MAG_W-1:0]        wm, norm_thresh;
  logic [NORM_CNT_W-1:0]   norm_cnt;
  logic [NORM_SH_W-1:0]    norm_sh;
  logic                    norm_take, norm_last;

  logic signed [ANG_W-1:0] roll_res, pitch_res, cd_angle;
  logic                    roll_axis, pitch_axis;

  cordic_req_t             cq;
  logic                    cd_done;
  logic                    rt_start, rt_done;
  logic [MAG_W-1:0]        rt_root;

  logic                    out_free, out_load;
  logic [SEQ_W-1:0]        frame_counter;
  risk_t                   risk;

  assign pready = 1'b1;

  trc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .regs    (cfg)
  );

  trc_cordic #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
    .CORDIC_STEPS    (CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .req   (cq),
    .done  (cd_done),
    .angle (cd_angle)
  );

  trc_isqrt u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (rt_start),
    .a     (mag_of(wy)),
    .b     (mag_of(wz)),
    .done  (rt_done),
    .root  (rt_root)
  );

  // axis cases are exact and skip the rotator
  assign roll_axis  = (in_y == '0) || (in_z == '0);
  assign pitch_axis = (in_x == '0) || ((in_y == '0) && (in_z == '0));

  // binary-search normalize: shift by 16, 8, 4, 2, 1 while top stays below 2^31
  assign norm_sh     = NORM_FIRST_SH >> norm_cnt;
  assign norm_thresh = NORM_TOP >> norm_sh;
  assign norm_take   = wm < norm_thresh;
  assign norm_last   = (norm_cnt == NORM_CNT_W'(NORM_STEPS - 1));

  assign out_free = !m_axis_tvalid || m_axis_tready;

  // ---------------- next state ----------------
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:        if (s_axis_tvalid) state_next = ST_ROLL_SETUP;
      ST_ROLL_SETUP:  state_next = roll_axis ? ST_PITCH_SETUP : ST_ROLL_NORM;
      ST_ROLL_NORM:   if (norm_last) state_next = ST_ROLL_START;
      ST_ROLL_START:  state_next = ST_ROLL_WAIT;
      ST_ROLL_WAIT:   if (cd_done) state_next = ST_PITCH_SETUP;
      ST_PITCH_SETUP: state_next = pitch_axis ? ST_DONE : ST_PITCH_NORM;
      ST_PITCH_NORM:  if (norm_last) state_next = ST_ROOT_START;
      ST_ROOT_START:  state_next = ST_ROOT_WAIT;
      ST_ROOT_WAIT:   if (rt_done) state_next = ST_PITCH_START;
      ST_PITCH_START: state_next = ST_PITCH_WAIT;
      ST_PITCH_WAIT:  if (cd_done) state_next = ST_DONE;
      ST_DONE:        if (out_free) state_next = ST_IDLE;
      default:        state_next = ST_IDLE;
    endcase
  end

  // ---------------- control outputs ----------------
  always_comb begin
    s_axis_tready = (state == ST_IDLE);
    rt_start      = (state == ST_ROOT_START);
    out_load      = (state == ST_DONE) && out_free;
    cq.start      = (state == ST_ROLL_START) || (state == ST_PITCH_START);
    if (state == ST_PITCH_START) begin
      // atan2(-px, |(py,pz)|), x side is never negative
      cq.y   = -wx;
      cq.x   = {(CW - MAG_W)'(0), rt_root};
      cq.acc = '0;
    end else if (wx[CW-1]) begin
      // left half plane: rotate by 180 and preset the accumulator
      cq.y   = -wy;
      cq.x   = -wx;
      cq.acc = wy[CW-1] ? -ACC_180 : ACC_180;
    end else begin
      cq.y   = wy;
      cq.x   = wx;
      cq.acc = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // ---------------- datapath ----------------
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          in_x     <= s_axis_tdata[A-1:0];
          in_y     <= s_axis_tdata[2*A-1:A];
          in_z     <= s_axis_tdata[3*A-1:2*A];
          in_dist  <= s_axis_tdata[3*A+DIST_BITS-1:3*A];
          in_valid <= s_axis_tuser[0];
        end
      end
      ST_ROLL_SETUP: begin
        // roll = atan2(ay, az)
        wy       <= CW'(in_y);
        wx       <= CW'(in_z);
        wm       <= max_of(mag_of(CW'(in_y)), mag_of(CW'(in_z)));
        norm_cnt <= '0;
        if (in_y == '0)      roll_res <= in_z[A-1] ? ANG_180 : '0;
        else if (in_z == '0) roll_res <= in_y[A-1] ? -ANG_90 : ANG_90;
      end
      ST_PITCH_SETUP: begin
        // all three axes scale together
        wx       <= CW'(in_x);
        wy       <= CW'(in_y);
        wz       <= CW'(in_z);
        wm       <= max_of(mag_of(CW'(in_x)),
                           max_of(mag_of(CW'(in_y)), mag_of(CW'(in_z))));
        norm_cnt <= '0;
        if (in_x == '0)                         pitch_res <= '0;
        else if ((in_y == '0) && (in_z == '0)) pitch_res <= in_x[A-1] ? ANG_90 : -ANG_90;
      end
      ST_ROLL_NORM, ST_PITCH_NORM: begin
        if (norm_take) begin
          wm <= wm << norm_sh;
          wx <= wx <<< norm_sh;
          wy <= wy <<< norm_sh;
          wz <= wz <<< norm_sh;
        end
        norm_cnt <= norm_cnt + NORM_CNT_W'(1);
      end
      ST_ROLL_WAIT:  if (cd_done) roll_res  <= cd_angle;
      ST_PITCH_WAIT: if (cd_done) pitch_res <= cd_angle;
      default: ;
    endcase
  end

  // ---------------- risk grading ----------------
  logic [ANG_W-1:0] roll_abs, pitch_abs, tilt_lim;
  logic [DXW-1:0]   dist_x, emer_x, caut_x;
  logic             tilt_hit, dist_nz;

  always_comb begin
    roll_abs  = roll_res[ANG_W-1]  ? ANG_W'(-roll_res)  : ANG_W'(roll_res);
    pitch_abs = pitch_res[ANG_W-1] ? ANG_W'(-pitch_res) : ANG_W'(pitch_res);
    tilt_lim  = ANG_W'(cfg.tilt_limit_deg) << ANGLE_FRAC_BITS;
    tilt_hit  = (roll_abs > tilt_lim) || (pitch_abs > tilt_lim);
    dist_x    = DXW'(in_dist);
    emer_x    = DXW'(cfg.emergency_distance_mm);
    caut_x    = DXW'(cfg.caution_distance_mm);
    dist_nz   = (in_dist != '0);
    if (!in_valid)                        risk = RISK_CAUTION;
    else if (dist_nz && dist_x < emer_x)  risk = RISK_EMERGENCY;
    else if (dist_nz && dist_x < caut_x)  risk = RISK_CAUTION;
    else if (tilt_hit)                    risk = RISK_CAUTION;
    else                                  risk = RISK_NORMAL;
  end

  // ---------------- output register ----------------
  logic [SEQ_W-1:0]                 seq_next;
  logic signed [ANG_W+ROLL_W-1:0]   roll_ext;
  logic signed [ANG_W+PITCH_W-1:0]  pitch_ext;
  logic [DIST_BITS+DOUT_W-1:0]      dist_ext;

  always_comb begin
    seq_next  = frame_counter + SEQ_W'(1);
    roll_ext  = (ANG_W + ROLL_W)'(roll_res);
    pitch_ext = (ANG_W + PITCH_W)'(pitch_res);
    dist_ext  = (DIST_BITS + DOUT_W)'(in_dist);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      frame_counter <= '0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
      frame_counter <= seq_next;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= {OUT_PAD_W'(0), risk, dist_ext[DOUT_W-1:0],
                       pitch_ext[PITCH_W-1:0], roll_ext[ROLL_W-1:0], seq_next};
    end
  end

endmodule
